/* src/sfta_pkg.sv */
// ----------------------------------------------------------------------------
// sfta_pkg: shared types and constants of the strip/fan triangle assembler
// Holds the queue token that the front end passes to the back end, the
// group and count constants, and the front-end mode encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package sfta_pkg;

  localparam int WORD_W          = 16;
  localparam int FACE_COUNT_BITS = 24;
  localparam int OUT_COUNT_W     = 24;
  localparam int GROUP_WORDS     = 4;
  localparam int MIN_VERTS       = 3;
  localparam int LEFT_W          = 15;
  localparam int PHASE_W         = $clog2(GROUP_WORDS);
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  // Front-end parse mode, one-hot.
  typedef enum logic [2:0] {
    MODE_HEADER = 3'b001,
    MODE_STRIP  = 3'b010,
    MODE_FAN    = 3'b100
  } mode_t;

  // One queued beat: a vertex index or a list-end marker.
  typedef struct packed {
    logic              is_end;
    logic              new_prim;
    logic              is_fan;
    logic [WORD_W-1:0] index;
  } token_t;

  // Queue occupancy status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* src/sfta_front.sv */
// ----------------------------------------------------------------------------
// sfta_front: command word parser
// Tracks header / group position and pushes one token per vertex group (its first
// word) and one per list terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module sfta_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          word_take,
  input  wire logic [sfta_pkg::WORD_W-1:0]   word,
  output logic                               push,
  output sfta_pkg::token_t                   push_tok
);

  sfta_pkg::mode_t                     mode_r, mode_nxt;
  logic [sfta_pkg::PHASE_W-1:0]        phase_r, phase_nxt;
  logic [sfta_pkg::LEFT_W-1:0]         left_r, left_nxt;
  logic                                new_prim_r, new_prim_nxt;

  localparam logic [sfta_pkg::PHASE_W-1:0] PHASE_LAST =
    sfta_pkg::PHASE_W'(sfta_pkg::GROUP_WORDS - 1);

  logic is_header;
  logic word_zero;

  assign is_header = (mode_r == sfta_pkg::MODE_HEADER);
  assign word_zero = (word == '0);

  always_comb begin
    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    new_prim_nxt = new_prim_r;
    push         = 1'b0;
    push_tok.is_end   = is_header;
    push_tok.new_prim = new_prim_r;
    push_tok.is_fan   = (mode_r == sfta_pkg::MODE_FAN);
    push_tok.index    = word;
    if (word_take) begin
      if (is_header) begin
        if (word_zero) begin
          push = 1'b1;
        end else begin
          phase_nxt    = '0;
          new_prim_nxt = 1'b1;
          if (word[sfta_pkg::WORD_W-1]) begin
            // magnitude - 1 of a negative count is its complement
            mode_nxt = sfta_pkg::MODE_FAN;
            left_nxt = ~word[sfta_pkg::LEFT_W-1:0];
          end else begin
            mode_nxt = sfta_pkg::MODE_STRIP;
            left_nxt = word[sfta_pkg::LEFT_W-1:0] - 1'b1;
          end
        end
      end else begin
        if (phase_r == '0) begin
          push         = 1'b1;
          new_prim_nxt = 1'b0;
        end
        if (phase_r == PHASE_LAST) begin
          phase_nxt = '0;
          if (left_r == '0) begin
            mode_nxt = sfta_pkg::MODE_HEADER;
          end else begin
            left_nxt = left_r - 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sfta_pkg::MODE_HEADER;
      phase_r    <= '0;
      left_r     <= '0;
      new_prim_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      new_prim_r <= new_prim_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/sfta_queue.sv */
// ----------------------------------------------------------------------------
// sfta_queue: token queue between parser and assembler
// Small register FIFO; pointers wrap over the depth.
// ----------------------------------------------------------------------------
`default_nettype none

module sfta_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sfta_pkg::token_t push_tok,
  input  wire logic             pop,
  output sfta_pkg::token_t      head_tok,
  output sfta_pkg::q_stat_t     stat
);

  localparam int DEPTH = sfta_pkg::QUEUE_DEPTH;

  sfta_pkg::token_t                slot_r [DEPTH];
  logic [sfta_pkg::QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sfta_pkg::QUEUE_CW-1:0]   count_r, count_nxt;

  function automatic logic [sfta_pkg::QUEUE_AW-1:0] ptr_inc(
    input logic [sfta_pkg::QUEUE_AW-1:0] p
  );
    if (p == sfta_pkg::QUEUE_AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat.full  = (count_r == sfta_pkg::QUEUE_CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_tok   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  // occupancy never runs past the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sfta_pkg::QUEUE_CW'(DEPTH))
    else $error("queue count above depth");

endmodule

`default_nettype wire

/* src/sfta_back.sv */
// ----------------------------------------------------------------------------
// sfta_back: triangle assembler
// Keeps the three-vertex window, strip winding and the per-list face count;
// loads the output register when it is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module sfta_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sfta_pkg::token_t                   tok,
  input  wire logic                               tok_valid,
  output logic                                    tok_pop,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output logic [sfta_pkg::WORD_W-1:0]             res_a,
  output logic [sfta_pkg::WORD_W-1:0]             res_b,
  output logic [sfta_pkg::WORD_W-1:0]             res_c,
  output logic                                    res_end,
  output logic [sfta_pkg::OUT_COUNT_W-1:0]        res_count
);

  localparam int FCB = sfta_pkg::FACE_COUNT_BITS;
  localparam logic [1:0] SEEN_FULL = 2'(sfta_pkg::MIN_VERTS);

  logic [1:0]                    seen_r, seen_nxt;
  logic                          flip_r, flip_nxt;
  logic [sfta_pkg::WORD_W-1:0]   h1_r, h2_r, h3_r, h1_nxt, h2_nxt, h3_nxt;
  logic [FCB-1:0]                faces_r, faces_nxt;

  logic                          emit;
  logic [sfta_pkg::WORD_W-1:0]   ta, tb, tc;
  logic [1:0]                    seen_eff;
  logic                          flip_eff;
  logic [31:0]                   faces_wide;

  logic                          out_v_r;
  logic [sfta_pkg::WORD_W-1:0]   out_a_r, out_b_r, out_c_r;
  logic                          out_end_r;
  logic [sfta_pkg::OUT_COUNT_W-1:0] out_cnt_r;

  assign tok_pop    = tok_valid && (!out_v_r || res_ready);
  assign faces_wide = 32'(faces_r);

  always_comb begin
    seen_nxt  = seen_r;
    flip_nxt  = flip_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    h3_nxt    = h3_r;
    faces_nxt = faces_r;
    emit      = 1'b0;
    ta        = tok.index;
    tb        = h3_r;
    tc        = h2_r;
    seen_eff  = tok.new_prim ? 2'd0 : seen_r;
    flip_eff  = tok.new_prim ? 1'b0 : flip_r;
    if (tok_pop && !tok.is_end) begin
      flip_nxt = flip_eff;
      case (seen_eff)
        2'd0: begin
          h1_nxt   = tok.index;
          seen_nxt = 2'd1;
        end
        2'd1: begin
          h2_nxt   = tok.index;
          seen_nxt = 2'd2;
        end
        2'd2: begin
          h3_nxt   = tok.index;
          seen_nxt = SEEN_FULL;
          emit     = 1'b1;
          ta       = h1_r;
          tb       = h2_r;
          tc       = tok.index;
        end
        default: begin
          emit   = 1'b1;
          h2_nxt = h3_r;
          h3_nxt = tok.index;
          if (tok.is_fan) begin
            ta = h1_r;
            tb = h3_r;
            tc = tok.index;
          end else begin
            h1_nxt   = h2_r;
            flip_nxt = !flip_eff;
            if (flip_eff) begin
              ta = h2_r;
              tb = h3_r;
              tc = tok.index;
            end else begin
              ta = tok.index;
              tb = h3_r;
              tc = h2_r;
            end
          end
        end
      endcase
      if (emit && (faces_r != '1)) begin
        faces_nxt = faces_r + 1'b1;
      end
    end else if (tok_pop) begin
      faces_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      flip_r  <= 1'b0;
      h1_r    <= '0;
      h2_r    <= '0;
      h3_r    <= '0;
      faces_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      flip_r  <= flip_nxt;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
      h3_r    <= h3_nxt;
      faces_r <= faces_nxt;
      if (tok_pop) begin
        out_v_r <= tok.is_end || emit;
      end else if (res_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      out_end_r <= tok.is_end;
      if (tok.is_end) begin
        out_a_r   <= '0;
        out_b_r   <= '0;
        out_c_r   <= '0;
        out_cnt_r <= faces_wide[sfta_pkg::OUT_COUNT_W-1:0];
      end else begin
        out_a_r   <= ta;
        out_b_r   <= tb;
        out_c_r   <= tc;
        out_cnt_r <= '0;
      end
    end
  end

  assign res_valid = out_v_r;
  assign res_a     = out_a_r;
  assign res_b     = out_b_r;
  assign res_c     = out_c_r;
  assign res_end   = out_end_r;
  assign res_count = out_cnt_r;

endmodule

`default_nettype wire

/* src/strip_fan_triangle_assembler.sv */
// ----------------------------------------------------------------------------
// strip_fan_triangle_assembler: strip/fan primitive assembly from a command
// stream
// Parses headers and four-word vertex groups, queues vertex indices and list
// terminators, and builds one triangle per vertex from the third onward.
// ----------------------------------------------------------------------------
//
//  channel  dir  ports                                   beat
//  -------  ---  --------------------------------------  ---------------------
//  in       in   in_valid/in_ready, in_word              one command word
//  out      out  out_valid/out_ready, out_vertex_a/b/c,  one triangle or one
//                out_end_of_list, out_face_count         list-end marker
//
//  One word per cycle while the token queue is not full; a result passes
//  through the 4-entry token queue and then the output register.
//  Front end (parser) stalls only when the token queue is full; back end
//  stalls only when the output register holds an untaken beat.
//  Reset (rst_n low, synchronous) returns the parser to header position and
//  clears the window, winding, face count, queue and output valid flag.
//  Headers of one or two vertices pass their groups through without a result.
//
`default_nettype none

module strip_fan_triangle_assembler (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [sfta_pkg::WORD_W-1:0]     in_word,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [sfta_pkg::WORD_W-1:0]          out_vertex_a,
  output logic signed [sfta_pkg::WORD_W-1:0]          out_vertex_b,
  output logic signed [sfta_pkg::WORD_W-1:0]          out_vertex_c,
  output logic                                        out_end_of_list,
  output logic [sfta_pkg::OUT_COUNT_W-1:0]            out_face_count
);

  // front-end to queue
  logic                 push;
  sfta_pkg::token_t     push_tok;
  // queue to back-end
  sfta_pkg::token_t     head_tok;
  sfta_pkg::q_stat_t    q_stat;
  logic                 pop;
  logic                 word_take;

  logic [sfta_pkg::WORD_W-1:0] va, vb, vc;

  // a word is taken whenever the queue has room for its token
  assign in_ready  = !q_stat.full;
  assign word_take = in_valid && in_ready;

  sfta_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_take (word_take),
    .word      (in_word),
    .push      (push),
    .push_tok  (push_tok)
  );

  sfta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .stat     (q_stat)
  );

  sfta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (head_tok),
    .tok_valid (!q_stat.empty),
    .tok_pop   (pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res_a     (va),
    .res_b     (vb),
    .res_c     (vc),
    .res_end   (out_end_of_list),
    .res_count (out_face_count)
  );

  assign out_vertex_a = $signed(va);
  assign out_vertex_b = $signed(vb);
  assign out_vertex_c = $signed(vc);

  // end markers carry no vertices
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_list) |->
      (out_vertex_a == '0 && out_vertex_b == '0 && out_vertex_c == '0))
    else $error("end marker with vertex data");

  // triangles carry no face count
  a_tri_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_list) |-> (out_face_count == '0))
    else $error("triangle with face count");

  // nothing is shown right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
